### hdl/email_address_syntax_checker_unit_assert.svh
// Assertion macros used by the checking module of the address syntax checker.
`ifndef EMAIL_ADDRESS_SYNTAX_CHECKER_UNIT_ASSERT_SVH
`define EMAIL_ADDRESS_SYNTAX_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define EASCU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and disabled during reset.
`define EASCU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/eascu_pkg.sv
// Shared types, constants and the character classifier of the address syntax checker.
package eascu_pkg;

    localparam int COUNT_BITS = 8;
    localparam int CFG_W      = 8;
    localparam int LEN_CMP_W  = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam int STATUS_W   = 3;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [CFG_W-1:0] LOCAL_MAX_RESET  = CFG_W'(64);
    localparam logic [CFG_W-1:0] DOMAIN_MAX_RESET = CFG_W'(63);

    localparam logic [7:0] CHAR_AT  = 8'h40;
    localparam logic [7:0] CHAR_DOT = 8'h2E;

    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [COUNT_BITS-1:0] len_t;

    localparam status_t ST_OK         = 3'd0;
    localparam status_t ST_NO_AT      = 3'd1;
    localparam status_t ST_MANY_AT    = 3'd2;
    localparam status_t ST_LENGTH     = 3'd3;
    localparam status_t ST_EDGE_DOT   = 3'd4;
    localparam status_t ST_DOUBLE_DOT = 3'd5;
    localparam status_t ST_BAD_CHAR   = 3'd6;
    localparam status_t ST_LOCAL_ONLY = 3'd7;

    localparam logic REG_LOCAL_MAX  = 1'b0;
    localparam logic REG_DOMAIN_MAX = 1'b1;

    typedef struct packed {
        logic is_at;
        logic is_dot;
        logic is_base;
        logic is_special;
        logic last;
    } item_t;

    function automatic item_t classify(input logic [7:0] c, input logic last);
        item_t r;
        r.is_at      = (c == CHAR_AT);
        r.is_dot     = (c == CHAR_DOT);
        r.is_base    = c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], 8'h2D, CHAR_DOT};
        r.is_special = c inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
                                 8'h2F, 8'h3D, 8'h3F, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7C,
                                 8'h7D, 8'h7E};
        r.last       = last;
        return r;
    endfunction

endpackage

### hdl/eascu_front.sv
// Input stage: accepts bytes and registers their character class.
module eascu_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,   // [7:0] char_byte
    input  logic            s_tlast,
    output logic            push,
    output eascu_pkg::item_t push_item,
    input  logic            q_ready
);
    import eascu_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;

    assign s_tready  = !valid_reg || q_ready;
    assign push      = valid_reg && q_ready;
    assign push_item = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
            item_next  = classify(s_tdata, s_tlast);
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

### hdl/eascu_queue.sv
// Short queue of classified characters between the input stage and the checker.
module eascu_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  eascu_pkg::item_t push_item,
    output logic             push_ready,
    input  logic             pop,
    output logic             pop_valid,
    output eascu_pkg::item_t pop_item
);
    import eascu_pkg::*;

    item_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/eascu_back.sv
// Checker stage: updates the address state per character and issues the status.
module eascu_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  eascu_pkg::item_t               q_item,
    output logic                           q_pop,
    input  logic [eascu_pkg::CFG_W-1:0]    local_max,
    input  logic [eascu_pkg::CFG_W-1:0]    domain_max,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata    // [2:0] status, [7:3] zero
);
    import eascu_pkg::*;

    logic [1:0] at_reg, at_next;
    len_t       llen_reg, llen_next;
    len_t       dlen_reg, dlen_next;
    logic       prev_dot_reg, prev_dot_next;
    logic       lsd_reg, lsd_next;
    logic       led_reg, led_next;
    logic       dsd_reg, dsd_next;
    status_t    err_reg, err_next;
    logic       out_valid_reg, out_valid_next;
    status_t    status_reg, status_next;
    status_t    status_calc;
    logic       len_bad;

    assign q_pop    = q_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - STATUS_W){1'b0}}, status_reg};

    always_comb
    begin
        at_next       = at_reg;
        llen_next     = llen_reg;
        dlen_next     = dlen_reg;
        prev_dot_next = prev_dot_reg;
        lsd_next      = lsd_reg;
        led_next      = led_reg;
        dsd_next      = dsd_reg;
        err_next      = err_reg;
        if (q_item.is_at)
        begin
            if (at_reg != 2'd2)
            begin
                at_next = at_reg + 1'b1;
            end
            if (at_reg == 2'd0)
            begin
                led_next = prev_dot_reg;
            end
            prev_dot_next = 1'b0;
        end
        else if (at_reg == 2'd0)
        begin
            if (llen_reg == '0 && q_item.is_dot)
            begin
                lsd_next = 1'b1;
            end
            if (llen_reg != '1)
            begin
                llen_next = llen_reg + 1'b1;
            end
            if (err_reg == ST_OK)
            begin
                if (q_item.is_dot && prev_dot_reg)
                begin
                    err_next = ST_DOUBLE_DOT;
                end
                else if (!q_item.is_base && !q_item.is_special)
                begin
                    err_next = ST_BAD_CHAR;
                end
            end
            prev_dot_next = q_item.is_dot;
        end
        else if (at_reg == 2'd1)
        begin
            if (dlen_reg == '0 && q_item.is_dot)
            begin
                dsd_next = 1'b1;
            end
            if (dlen_reg != '1)
            begin
                dlen_next = dlen_reg + 1'b1;
            end
            if (err_reg == ST_OK)
            begin
                if (q_item.is_dot && prev_dot_reg)
                begin
                    err_next = ST_DOUBLE_DOT;
                end
                else if (q_item.is_special)
                begin
                    err_next = ST_LOCAL_ONLY;
                end
                else if (!q_item.is_base)
                begin
                    err_next = ST_BAD_CHAR;
                end
            end
            prev_dot_next = q_item.is_dot;
        end

        len_bad = (llen_next == '0) || (dlen_next == '0) ||
                  (LEN_CMP_W'(llen_next) > LEN_CMP_W'(local_max)) ||
                  (LEN_CMP_W'(dlen_next) > LEN_CMP_W'(domain_max));

        if (at_next == 2'd0)
        begin
            status_calc = ST_NO_AT;
        end
        else if (at_next == 2'd2)
        begin
            status_calc = ST_MANY_AT;
        end
        else if (len_bad)
        begin
            status_calc = ST_LENGTH;
        end
        else if (lsd_next || led_next || dsd_next || prev_dot_next)
        begin
            status_calc = ST_EDGE_DOT;
        end
        else
        begin
            status_calc = err_next;
        end

        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (q_pop && q_item.last)
        begin
            out_valid_next = 1'b1;
            status_next    = status_calc;
            at_next        = 2'd0;
            llen_next      = '0;
            dlen_next      = '0;
            prev_dot_next  = 1'b0;
            lsd_next       = 1'b0;
            led_next       = 1'b0;
            dsd_next       = 1'b0;
            err_next       = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_reg        <= 2'd0;
            llen_reg      <= '0;
            dlen_reg      <= '0;
            prev_dot_reg  <= 1'b0;
            lsd_reg       <= 1'b0;
            led_reg       <= 1'b0;
            dsd_reg       <= 1'b0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                at_reg       <= at_next;
                llen_reg     <= llen_next;
                dlen_reg     <= dlen_next;
                prev_dot_reg <= prev_dot_next;
                lsd_reg      <= lsd_next;
                led_reg      <= led_next;
                dsd_reg      <= dsd_next;
                err_reg      <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

endmodule

### hdl/email_address_syntax_checker_unit.sv
// Top level of the address syntax checker: register port, input stage, queue and checker.
// m_tvalid rises once the last byte has passed the input stage, the queue and the checker.
// Throughput: one byte per cycle unless the output stalls; the checker updates per character.
// A stalled status halts the checker; the input stage and queue then take up to three bytes.
// Reset: rst_n clears all address state, the queue and the output; limits return to 64 and 63.
module email_address_syntax_checker_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [2:0] status, [7:3] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import eascu_pkg::*;

    logic [CFG_W-1:0] local_max_reg, domain_max_reg;
    logic             push, q_ready, q_pop, q_valid;
    item_t            push_item, q_item;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_max_reg  <= LOCAL_MAX_RESET;
            domain_max_reg <= DOMAIN_MAX_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_LOCAL_MAX)
            begin
                local_max_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                domain_max_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_LOCAL_MAX:  prdata = {{(32 - CFG_W){1'b0}}, local_max_reg};
            REG_DOMAIN_MAX: prdata = {{(32 - CFG_W){1'b0}}, domain_max_reg};
            default:        prdata = '0;
        endcase
    end

    eascu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready)
    );

    eascu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_item   (q_item)
    );

    eascu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .local_max  (local_max_reg),
        .domain_max (domain_max_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

### hdl/eascu_checker.sv
// Port-level assertions for the address syntax checker and their binding to the top level.
`include "email_address_syntax_checker_unit_assert.svh"

module eascu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    `EASCU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "status request dropped or changed while stalled")
    `EASCU_ASSERT_IMPL(a_pad_zero, m_tvalid, m_tdata[7:3] == 5'd0, "status padding bits are not zero")
    `EASCU_ASSERT_IMPL(a_no_result_early, $past(!rst_n) && rst_n, !m_tvalid, "status presented straight out of reset")
    `EASCU_ASSERT_NEXT(a_reg_readback, psel && penable && pwrite && pready && !paddr[2], paddr[2] || (prdata[7:0] == $past(pwdata[7:0])), "limit register read back differs from the value written")

endmodule

bind email_address_syntax_checker_unit eascu_checker u_eascu_checker (.*);

### tb/email_address_syntax_checker_unit_test.sv
// Self-checking testbench of the address syntax checker: byte stream in, status out, APB limits.
`timescale 1ns / 100ps

module email_address_syntax_checker_unit_test;
    import eascu_pkg::*;

    localparam logic [2:0] ADDR_LOCAL_LIMIT  = 3'd0;
    localparam logic [2:0] ADDR_DOMAIN_LIMIT = 3'd4;
    localparam int IDLE_LIMIT   = 500;
    localparam int SETTLE_TICKS = 8;
    localparam logic [7:0] SPECIAL_CHARS [18] = '{
        8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2F,
        8'h3D, 8'h3F, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E
    };

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        logic [3:0] gap;
    } byte_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // [7:0] char_byte
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [2:0] status, [7:3] zero
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    byte_req_t  pending[$];
    status_t    status_due[$];
    byte_req_t  next_req;
    logic [3:0] send_wait = 4'd0;
    int         recv_wait = 0;
    int         recv_hold;
    bit         recv_idling = 1'b0;
    int         queued_bytes = 0;
    int         accepted_bytes = 0;
    int         checked_statuses = 0;
    int         failures = 0;
    int         quiet_cycles = 0;
    int         status_seen [8] = '{default: 0};

    logic [7:0] local_limit  = LOCAL_MAX_RESET;
    logic [7:0] domain_limit = DOMAIN_MAX_RESET;
    logic [1:0] at_seen = 2'd0;
    len_t       local_cnt = '0;
    len_t       domain_cnt = '0;
    logic       prev_was_dot = 1'b0;
    logic       local_lead_dot = 1'b0;
    logic       local_trail_dot = 1'b0;
    logic       domain_lead_dot = 1'b0;
    status_t    first_err = ST_OK;

    email_address_syntax_checker_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit is_plain_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == "-" || c == CHAR_DOT;
    endfunction

    function automatic bit is_special_char(input logic [7:0] c);
        bit hit;
        hit = 1'b0;
        foreach (SPECIAL_CHARS[k])
            if (SPECIAL_CHARS[k] == c)
                hit = 1'b1;
        return hit;
    endfunction

    function automatic void note_char_fault(input status_t code);
        if (first_err == ST_OK)
            first_err = code;
    endfunction

    function automatic len_t count_up(input len_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Updates the address state with one accepted byte and predicts the status on the final byte.
    function automatic void absorb_char(input logic [7:0] c, input logic fin);
        logic    dot;
        status_t verdict;
        dot = (c == CHAR_DOT);
        if (c == CHAR_AT)
        begin
            if (at_seen < 2'd2)
                at_seen = at_seen + 2'd1;
            if (at_seen == 2'd1)
                local_trail_dot = prev_was_dot;
            prev_was_dot = 1'b0;
        end
        else if (at_seen == 2'd0)
        begin
            if (local_cnt == 0 && dot)
                local_lead_dot = 1'b1;
            local_cnt = count_up(local_cnt);
            if (dot && prev_was_dot)
                note_char_fault(ST_DOUBLE_DOT);
            else if (!is_plain_char(c) && !is_special_char(c))
                note_char_fault(ST_BAD_CHAR);
            prev_was_dot = dot;
        end
        else if (at_seen == 2'd1)
        begin
            if (domain_cnt == 0 && dot)
                domain_lead_dot = 1'b1;
            domain_cnt = count_up(domain_cnt);
            if (dot && prev_was_dot)
                note_char_fault(ST_DOUBLE_DOT);
            else if (is_special_char(c))
                note_char_fault(ST_LOCAL_ONLY);
            else if (!is_plain_char(c))
                note_char_fault(ST_BAD_CHAR);
            prev_was_dot = dot;
        end
        if (fin)
        begin
            if (at_seen == 2'd0)
                verdict = ST_NO_AT;
            else if (at_seen == 2'd2)
                verdict = ST_MANY_AT;
            else if (local_cnt == 0 || local_cnt > local_limit ||
                     domain_cnt == 0 || domain_cnt > domain_limit)
                verdict = ST_LENGTH;
            else if (local_lead_dot || local_trail_dot || domain_lead_dot || prev_was_dot)
                verdict = ST_EDGE_DOT;
            else
                verdict = first_err;
            status_due.push_back(verdict);
            at_seen = 2'd0;
            local_cnt = '0;
            domain_cnt = '0;
            prev_was_dot = 1'b0;
            local_lead_dot = 1'b0;
            local_trail_dot = 1'b0;
            domain_lead_dot = 1'b0;
            first_err = ST_OK;
        end
    endfunction

    function automatic int draw_stall();
        if (recv_idling && $urandom_range(0, 2) != 0)
            return $urandom_range(0, 11);
        return 0;
    endfunction

    // Byte source.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'd0;
            s_tlast <= 1'b0;
            send_wait <= 4'd0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (send_wait != 4'd0)
            begin
                s_tvalid <= 1'b0;
                send_wait <= send_wait - 4'd1;
            end
            else if (pending.size() != 0)
            begin
                next_req = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= next_req.ch;
                s_tlast <= next_req.fin;
                send_wait <= next_req.gap;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Status sink with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            recv_hold = recv_wait;
            if (m_tvalid && m_tready)
                recv_hold = draw_stall();
            if (recv_hold != 0)
            begin
                m_tready <= 1'b0;
                recv_wait <= recv_hold - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                recv_wait <= 0;
            end
        end
    end

    // Monitor: predicts on each byte request and checks each status request.
    always @(posedge clk)
    begin : monitor
        status_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                accepted_bytes++;
                absorb_char(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                if (status_due.size() == 0)
                begin
                    $error("status %0d arrived with none expected", m_tdata[2:0]);
                    failures++;
                end
                else
                begin
                    want = status_due.pop_front();
                    checked_statuses++;
                    status_seen[want]++;
                    if (m_tdata[2:0] !== want)
                    begin
                        $error("status: expected %0d, got %0d", want, m_tdata[2:0]);
                        failures++;
                    end
                    if (m_tdata[7:3] !== 5'd0)
                    begin
                        $error("status padding: expected 0, got %0h", m_tdata[7:3]);
                        failures++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("Timed out after %0d cycles without a request", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic write_limit(input logic [2:0] addr, input logic [7:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_LOCAL_LIMIT)
            local_limit = value;
        else
            domain_limit = value;
    endtask

    task automatic push_byte(input logic [7:0] c, input logic fin, input bit gaps);
        byte_req_t r;
        r.ch = c;
        r.fin = fin;
        r.gap = gaps ? 4'($urandom_range(0, 11)) : 4'd0;
        pending.push_back(r);
        queued_bytes++;
    endtask

    task automatic push_text(input string s, input bit gaps);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], i == s.len() - 1, gaps);
    endtask

    function automatic int pick_len(input int lim, input bit very_long);
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (very_long)
            return $urandom_range(250, 300);
        if (r == 0)
            return 0;
        if (r < 3)
        begin
            v = lim + int'($urandom_range(0, 2)) - 1;
            return (v < 0) ? 0 : v;
        end
        return $urandom_range(1, 6);
    endfunction

    function automatic logic [7:0] part_char();
        int r;
        int p;
        r = $urandom_range(0, 99);
        p = $urandom_range(0, 62);
        if (r < 80)
        begin
            if (p < 26)
                return 8'("a" + p);
            if (p < 52)
                return 8'("A" + p - 26);
            if (p < 62)
                return 8'("0" + p - 52);
            return "-";
        end
        if (r < 87)
            return CHAR_DOT;
        if (r < 95)
            return SPECIAL_CHARS[$urandom_range(0, 17)];
        return 8'($urandom_range(0, 255));
    endfunction

    // long_side: 0 none, 1 local part, 2 domain part.
    task automatic queue_random_address(input int long_side);
        bit gaps;
        int kind;
        int llen;
        int dlen;
        int n;
        gaps = ($urandom_range(0, 3) != 0);
        kind = $urandom_range(0, 9);
        if (kind < 2 && long_side == 0)
        begin
            n = $urandom_range(1, 12);
            for (int k = 0; k < n; k++)
                push_byte(8'($urandom_range(0, 255)), k == n - 1, gaps);
        end
        else
        begin
            llen = pick_len(local_limit, long_side == 1);
            dlen = pick_len(domain_limit, long_side == 2);
            for (int k = 0; k < llen; k++)
                push_byte(part_char(), 1'b0, gaps);
            if (kind == 2)
                push_byte(CHAR_AT, 1'b0, gaps);
            push_byte(CHAR_AT, dlen == 0, gaps);
            for (int k = 0; k < dlen; k++)
                push_byte(part_char(), k == dlen - 1, gaps);
        end
    endtask

    task automatic wait_until_idle();
        while (pending.size() != 0 || s_tvalid || status_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic run_phase(input logic [7:0] lmax, input logic [7:0] dmax, input int nbytes,
                             input bit with_long);
        int target;
        write_limit(ADDR_LOCAL_LIMIT, lmax);
        write_limit(ADDR_DOMAIN_LIMIT, dmax);
        recv_idling = 1'b1;
        target = queued_bytes + nbytes;
        if (with_long)
            queue_random_address($urandom_range(1, 2));
        while (queued_bytes < target)
            queue_random_address(0);
        wait_until_idle();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_text("a@b", 1'b0);
        push_text("z", 1'b0);
        push_byte(CHAR_AT, 1'b0, 1'b0);
        push_byte(CHAR_AT, 1'b0, 1'b0);
        push_byte(8'h00, 1'b1, 1'b0);
        push_text("@9", 1'b0);
        push_text("a.@.b", 1'b0);
        push_text("a@b..c", 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_text("@~", 1'b0);
        push_text("~@{", 1'b0);
        wait_until_idle();

        run_phase(8'd1, 8'd1, 40, 1'b0);
        run_phase(8'd255, 8'd255, 40, 1'b1);
        run_phase(8'd0, 8'd0, 20, 1'b0);
        run_phase(8'($urandom_range(2, 20)), 8'($urandom_range(2, 20)), 60, 1'b0);
        run_phase(LOCAL_MAX_RESET, DOMAIN_MAX_RESET, 40, 1'b0);

        $display("Checked %0d statuses from %0d bytes under limits of 64/63, 1/1, 255/255, 0/0,",
                 checked_statuses, accepted_bytes);
        $display("random and back to reset; status counts 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/eascu_pkg.sv
hdl/eascu_front.sv
hdl/eascu_queue.sv
hdl/eascu_back.sv
hdl/email_address_syntax_checker_unit.sv
hdl/eascu_checker.sv
tb/email_address_syntax_checker_unit_test.sv
